// ----- src/rbdq_pkg.sv -----
`default_nettype none

package rbdq_pkg;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 10;
    localparam int OCC_W  = 11;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
        logic signed [VAL_W-1:0] indexed_value;
        logic [OCC_W-1:0]        occupancy;
        logic                    is_empty;
        logic [STAT_W-1:0]       status;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/ring_buffer_deque_top.sv -----
// The result strobe follows an accepted transaction through r_busy and then r_strobe.
// A new transaction is not accepted while busy; busy is high for the cycle after
// an accept, while the single memory read port returns the pop or index lookup.
// Reset (synchronous, active low) empties the queue and zeroes both pointers;
// the storage memory is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module ring_buffer_deque_top #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rbdq_pkg::t_in_item i_item,
    output logic                    o_strobe,
    output rbdq_pkg::t_out_item     o_result
);

    import rbdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    rbdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    rbdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- src/rbdq_mem.sv -----
`default_nettype none

module rbdq_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic                  i_re,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/rbdq_ctrl.sv -----
`default_nettype none

module rbdq_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire rbdq_pkg::t_in_item    i_item,
    output logic                       o_strobe,
    output rbdq_pkg::t_out_item        o_result,
    output logic                       o_mem_we,
    output logic      [AW-1:0]         o_mem_waddr,
    output logic      [DATA_WIDTH-1:0] o_mem_wdata,
    output logic                       o_mem_re,
    output logic      [AW-1:0]         o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_mem_rdata
);

    import rbdq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int SW   = CMPW + 2;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic                  r_busy, n_busy;
    logic                  r_strobe, n_strobe;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;
    logic                  r_upd_front, n_upd_front;
    logic                  r_upd_back, n_upd_back;
    logic                  r_idx_rd, n_idx_rd;
    logic [STAT_W-1:0]     r_status, n_status;
    t_out_item             r_result, n_result;

    logic                  accept;
    logic [AW-1:0]         head_up, head_dn, tail_up, tail_dn;
    logic [CMPW-1:0]       pos_w, cnt_w;
    logic                  in_range;
    logic [SW-1:0]         slot_raw, slot_fix;
    logic [AW-1:0]         idx_slot;
    logic [63:0]           val64;
    logic [DATA_WIDTH-1:0] value_d;
    logic [31:0]           cnt32;

    function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[VAL_W-1:0];
    endfunction

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign head_up = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign head_dn = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign tail_up = (r_tail == LAST_SLOT) ? '0 : r_tail + AW'(1);
    assign tail_dn = (r_tail == '0) ? LAST_SLOT : r_tail - AW'(1);

    // front sits at head, position p lives p slots below it
    assign pos_w    = CMPW'(i_item.position);
    assign cnt_w    = CMPW'(r_count);
    assign in_range = pos_w < cnt_w;
    assign slot_raw = SW'(r_head) + SW'(DEPTH) - SW'(pos_w);
    assign slot_fix = (slot_raw >= SW'(DEPTH)) ? slot_raw - SW'(DEPTH) : slot_raw;
    assign idx_slot = slot_fix[AW-1:0];

    assign val64   = {32'h0, i_item.value};
    assign value_d = val64[DATA_WIDTH-1:0];
    assign cnt32   = 32'(r_count);

    always_comb begin
        n_busy      = accept;
        n_strobe    = r_busy;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_upd_front = r_upd_front;
        n_upd_back  = r_upd_back;
        n_idx_rd    = r_idx_rd;
        n_status    = r_status;
        n_result    = r_result;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = value_d;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        if (accept) begin
            n_upd_front = 1'b0;
            n_upd_back  = 1'b0;
            n_idx_rd    = 1'b0;
            n_status    = ST_OK;
            case (i_item.kind)
                KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                    if (r_count == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + CW'(1);
                        if (r_count == '0) begin
                            n_head      = '0;
                            n_tail      = '0;
                            o_mem_waddr = '0;
                            n_front     = value_d;
                            n_back      = value_d;
                        end else if (i_item.kind == KIND_PUSH_BACK) begin
                            n_tail      = tail_dn;
                            o_mem_waddr = tail_dn;
                            n_back      = value_d;
                        end else begin
                            n_head      = head_up;
                            o_mem_waddr = head_up;
                            n_front     = value_d;
                        end
                    end
                end
                KIND_POP_BACK, KIND_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (r_count == CW'(1)) begin
                        n_count = '0;
                        n_head  = '0;
                        n_tail  = '0;
                    end else begin
                        n_count  = r_count - CW'(1);
                        o_mem_re = 1'b1;
                        if (i_item.kind == KIND_POP_BACK) begin
                            n_tail      = tail_up;
                            o_mem_raddr = tail_up;
                            n_upd_back  = 1'b1;
                        end else begin
                            n_head      = head_dn;
                            o_mem_raddr = head_dn;
                            n_upd_front = 1'b1;
                        end
                    end
                end
                KIND_READ: begin
                    if (!in_range) begin
                        n_status = ST_RANGE;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = idx_slot;
                        n_idx_rd    = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    n_count = '0;
                    n_head  = '0;
                    n_tail  = '0;
                end
                default: begin
                end
            endcase
        end

        // while busy: refresh the cached end value from the lookup, build the result
        if (r_busy) begin
            if (r_upd_front) begin
                n_front = i_mem_rdata;
            end
            if (r_upd_back) begin
                n_back = i_mem_rdata;
            end
            n_result.front_value   = (r_count == '0) ? '0 : to_out(n_front);
            n_result.back_value    = (r_count == '0) ? '0 : to_out(n_back);
            n_result.indexed_value = r_idx_rd ? to_out(i_mem_rdata) : '0;
            n_result.occupancy     = cnt32[OCC_W-1:0];
            n_result.is_empty      = (r_count == '0);
            n_result.status        = r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_strobe    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_upd_front <= 1'b0;
            r_upd_back  <= 1'b0;
            r_idx_rd    <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_busy      <= n_busy;
            r_strobe    <= n_strobe;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_upd_front <= n_upd_front;
            r_upd_back  <= n_upd_back;
            r_idx_rd    <= n_idx_rd;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_back   <= n_back;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- src/rbdq_checker.sv -----
`default_nettype none

module rbdq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_strobe,
    input wire rbdq_pkg::t_out_item o_result
);

    import rbdq_pkg::*;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_strobe)
        else $error("accepted transaction produced no result");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_strobe)
        else $error("busy not raised after accept");

    a_empty_ends_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.is_empty |->
            o_result.front_value == 0 && o_result.back_value == 0)
        else $error("empty queue reports nonzero end value");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_RANGE |-> o_result.indexed_value == 0)
        else $error("out-of-range read reports nonzero value");

endmodule

bind ring_buffer_deque_top rbdq_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
